// ===== sv/tcp_option_tlv_parser_assert.svh =====
// ----------------------------------------------------------------------------
// tcp option tlv parser assertion macros
// concurrent assertion shorthands, clocked on clk with active-low reset
// ----------------------------------------------------------------------------
`ifndef TCP_OPTION_TLV_PARSER_ASSERT_SVH
`define TCP_OPTION_TLV_PARSER_ASSERT_SVH

// same-cycle implication
`define TCPO_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcp option parser: same-cycle check failed");

// next-cycle implication
`define TCPO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcp option parser: next-cycle check failed");

`endif

// ===== sv/tcpo_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpo_pkg
// shared types, status codes and limits of the tcp option tlv parser
// ----------------------------------------------------------------------------
`default_nettype none

package tcpo_pkg;

  localparam logic [5:0] MAX_AREA_BYTES = 6'd40;

  localparam logic [2:0] ST_OPTION  = 3'd0;
  localparam logic [2:0] ST_END     = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_BADLEN  = 3'd3;
  localparam logic [2:0] ST_OVERRUN = 3'd4;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] option_type;
    logic [7:0] option_length;
    logic [5:0] data_offset;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic result_t make_res(input logic [2:0] status,
                                       input logic [7:0] option_type,
                                       input logic [7:0] option_length,
                                       input logic [5:0] data_offset,
                                       input logic       last);
    result_t r;
    r.status        = status;
    r.option_type   = option_type;
    r.option_length = option_length;
    r.data_offset   = data_offset;
    r.last          = last;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tcp_option_tlv_parser.sv =====
// each result is registered in the result queue and shows on out_* from its head
// throughput: one option byte per cycle while in_stall is low; a byte may yield up to two words
// in_stall rises while the four-entry result queue holds three or more words
// the queue drains one word per cycle as out_stall allows
// reset (rst_n low, synchronous) empties the queue and leaves the parser
// waiting for an area start
// ----------------------------------------------------------------------------
// tcp_option_tlv_parser
// walks tcp option areas byte by byte and reports each kind-length option
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_option_tlv_parser
  import tcpo_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_area_start,
  input  wire logic [5:0] in_area_length,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_status,
  output logic [7:0]      out_option_type,
  output logic [7:0]      out_option_length,
  output logic [5:0]      out_data_offset,
  output logic            out_last
);

  push_t   push;
  result_t res;
  logic    in_accept;

  assign in_accept = in_valid && !in_stall;

  tcpo_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .data_byte   (in_data_byte),
    .area_start  (in_area_start),
    .area_length (in_area_length),
    .push        (push)
  );

  tcpo_res_fifo u_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full_for_two (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res      (res)
  );

  assign out_status        = res.status;
  assign out_option_type   = res.option_type;
  assign out_option_length = res.option_length;
  assign out_data_offset   = res.data_offset;
  assign out_last          = res.last;

endmodule

`default_nettype wire

// ===== sv/tcpo_parser.sv =====
// ----------------------------------------------------------------------------
// tcpo_parser
// per-byte option walker: state registers and the single-pass step logic
// ----------------------------------------------------------------------------
`default_nettype none

module tcpo_parser
  import tcpo_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       area_start,
  input  wire logic [5:0] area_length,
  output push_t           push
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_KIND = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [5:0] left_r, left_nxt;
  logic [5:0] obl_r, obl_nxt;
  logic [7:0] type_r, type_nxt;
  logic [5:0] pos_r, pos_nxt;

  logic [5:0] alen;
  logic [1:0] w_phase;
  logic [5:0] w_left;
  logic [5:0] w_obl;
  logic [7:0] w_type;
  logic [5:0] w_pos;
  logic [5:0] pos_inc;
  logic       done;
  logic [1:0] n;
  result_t    r0;
  result_t    r1;

  always_comb begin
    alen    = (area_length > MAX_AREA_BYTES) ? MAX_AREA_BYTES : area_length;
    w_phase = phase_r;
    w_left  = left_r;
    w_obl   = obl_r;
    w_type  = type_r;
    w_pos   = pos_r;
    pos_inc = pos_r + 6'd1;
    done    = 1'b0;
    n       = 2'd0;
    r0      = make_res(ST_OPTION, 8'd0, 8'd0, 6'd0, 1'b0);
    r1      = make_res(ST_OPTION, 8'd0, 8'd0, 6'd0, 1'b0);
    if (accept) begin
      if (area_start) begin
        w_phase = PH_KIND;
        w_left  = alen;
        w_obl   = 6'd0;
        w_type  = 8'd0;
        w_pos   = 6'd0;
        pos_inc = 6'd1;
      end
      if (area_start && (alen == 6'd0)) begin
        r0      = make_res(ST_MISSING, 8'd0, 8'd0, 6'd0, 1'b1);
        n       = 2'd1;
        w_phase = PH_IDLE;
      end else if ((w_phase == PH_IDLE) || (w_left == 6'd0)) begin
        w_phase = PH_IDLE;
      end else begin
        unique case (w_phase)
          PH_KIND: begin
            if (data_byte == 8'd0) begin
              r0      = make_res(ST_END, 8'd0, 8'd0, 6'd0, 1'b1);
              n       = 2'd1;
              w_phase = PH_IDLE;
              done    = 1'b1;
            end else if (data_byte != 8'd1) begin
              if (w_left == 6'd1) begin
                r0      = make_res(ST_OVERRUN, data_byte, 8'd0, 6'd0, 1'b1);
                n       = 2'd1;
                w_phase = PH_IDLE;
                done    = 1'b1;
              end else begin
                w_type  = data_byte;
                w_phase = PH_LEN;
              end
            end
          end
          PH_LEN: begin
            if (data_byte < 8'd2) begin
              r0      = make_res(ST_BADLEN, w_type, data_byte, 6'd0, 1'b1);
              n       = 2'd1;
              w_phase = PH_IDLE;
              done    = 1'b1;
            end else if ({1'b0, data_byte} > ({3'd0, w_left} + 9'd1)) begin
              r0      = make_res(ST_OVERRUN, w_type, data_byte, pos_inc, 1'b1);
              n       = 2'd1;
              w_phase = PH_IDLE;
              done    = 1'b1;
            end else begin
              r0 = make_res(ST_OPTION, w_type, data_byte, pos_inc, 1'b0);
              n  = 2'd1;
              if (data_byte == 8'd2) begin
                w_phase = PH_KIND;
              end else begin
                w_obl   = data_byte[5:0] - 6'd2;
                w_phase = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            if (w_obl != 6'd0) begin
              w_obl = w_obl - 6'd1;
            end
            if (w_obl == 6'd0) begin
              w_phase = PH_KIND;
            end
          end
          PH_IDLE: begin
            w_phase = PH_IDLE;
          end
          default: begin
            w_phase = PH_IDLE;
          end
        endcase
        if (!done) begin
          w_left = w_left - 6'd1;
          w_pos  = pos_inc;
          if (w_left == 6'd0) begin
            if (n == 2'd0) begin
              r0 = make_res(ST_MISSING, 8'd0, 8'd0, 6'd0, 1'b1);
            end else begin
              r1 = make_res(ST_MISSING, 8'd0, 8'd0, 6'd0, 1'b1);
            end
            n       = n + 2'd1;
            w_phase = PH_IDLE;
          end
        end
      end
    end
    phase_nxt  = w_phase;
    left_nxt   = w_left;
    obl_nxt    = w_obl;
    type_nxt   = w_type;
    pos_nxt    = w_pos;
    push.count = n;
    push.res0  = r0;
    push.res1  = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      left_r  <= 6'd0;
      obl_r   <= 6'd0;
      type_r  <= 8'd0;
      pos_r   <= 6'd0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      obl_r   <= obl_nxt;
      type_r  <= type_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tcpo_res_fifo.sv =====
// ----------------------------------------------------------------------------
// tcpo_res_fifo
// four-entry result queue, takes up to two results and gives one per cycle while out_stall is low
// ----------------------------------------------------------------------------
`default_nettype none

module tcpo_res_fifo
  import tcpo_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       full_for_two,
  output logic       out_valid,
  input  wire logic  out_stall,
  output result_t    out_res
);

  result_t    mem [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;
  logic [1:0] wr_ptr_p1;

  assign wr_ptr_p1    = wr_ptr_r + 2'd1;
  assign out_valid    = (count_r != 3'd0);
  assign out_res      = mem[rd_ptr_r];
  assign full_for_two = (count_r > 3'd2);
  assign pop          = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.count;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push.count} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_p1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tcpo_checker.sv =====
// ----------------------------------------------------------------------------
// tcpo_checker
// port-level checks of the tcp option tlv parser, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "tcp_option_tlv_parser_assert.svh"

module tcpo_checker
  import tcpo_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_status,
  input wire logic [7:0] out_option_type,
  input wire logic [7:0] out_option_length,
  input wire logic [5:0] out_data_offset,
  input wire logic       out_last
);

  logic [25:0] out_word;

  assign out_word = {out_status, out_option_type, out_option_length, out_data_offset,
                     out_last};

  `TCPO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  `TCPO_ASSERT_SAME(a_empty_accepts, !out_valid, !in_stall)

  `TCPO_ASSERT_SAME(a_last_by_status, out_valid, out_last == (out_status != ST_OPTION))

  `TCPO_ASSERT_SAME(a_option_fields, out_valid && (out_status == ST_OPTION), (out_option_length > 8'd1) && (out_data_offset != 6'd0))

endmodule

bind tcp_option_tlv_parser tcpo_checker u_tcpo_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_option_type   (out_option_type),
  .out_option_length (out_option_length),
  .out_data_offset   (out_data_offset),
  .out_last          (out_last)
);

`default_nettype wire
